FILE: src/tpwu_pkg.sv
// ----------------------------------------------------------------------------
// tpwu_pkg
// Types and constants shared by the turret PI control with wrap unwind block.
// ----------------------------------------------------------------------------
package tpwu_pkg;

    // Fixed-point constants, Q4.12 radians and effort units
    localparam int WrapQ12      = 12288;
    localparam int PiQ12        = 12868;
    localparam int UnwindEffort = 100;
    localparam int EffortMax    = 32767;
    localparam int PiFracBits   = 20;

    // Configuration port geometry
    localparam int CfgIndexW = 3;
    localparam int CfgDataW  = 23;

    // Register indexes
    localparam logic [CfgIndexW-1:0] RegEnable        = 3'd0;
    localparam logic [CfgIndexW-1:0] RegPropGain      = 3'd1;
    localparam logic [CfgIndexW-1:0] RegIntegGain     = 3'd2;
    localparam logic [CfgIndexW-1:0] RegIntegralLimit = 3'd3;
    localparam logic [CfgIndexW-1:0] RegTurnMargin    = 3'd4;
    localparam logic [CfgIndexW-1:0] RegTurnBuffer    = 3'd5;

    // Input transaction
    typedef struct packed {
        logic signed [14:0] angle_sample;
        logic signed [15:0] error_sample;
    } in_t;

    // Result transaction
    typedef struct packed {
        logic signed [15:0] drive_effort;
        logic               unwinding;
        logic               wound_flag;
    } out_t;

    // Configuration registers as seen by the stages
    typedef struct packed {
        logic               enable;
        logic signed [15:0] prop_gain;
        logic signed [15:0] integ_gain;
        logic        [22:0] integral_limit;
        logic        [13:0] turn_margin;
        logic        [13:0] turn_buffer;
    } cfg_t;

    // Between the integral stage and the control stage
    typedef struct packed {
        logic signed [14:0] angle;
        logic signed [31:0] prop_prod;
        logic signed [39:0] integ_prod;
    } mid_t;

endpackage

FILE: src/turret_pi_control_with_wrap_unwind.sv
// ----------------------------------------------------------------------------
// turret_pi_control_with_wrap_unwind
// Turret PI loop with wrap detection and fixed-effort unwind.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one control tick: the
//   sampled angle and error. Output channel (out_valid/out_ready/out_data)
//   returns one result per tick: effort, unwinding and wound flags.
//   Configuration is written through cfg_we/cfg_index/cfg_data, one register
//   per cycle, while the block is idle; unknown indexes are ignored.
// Pipeline and throughput:
//   A transaction passes through the input register, the product register
//   and the result register before its result is valid. One transaction per
//   cycle is sustained while the receiver keeps out_ready high; the
//   integral update and the gain products share the first stage, the unwind
//   sequencer and PI scaling the second.
// Reset:
//   rst_n clears all configuration, the integral and the unwind state, and
//   empties the pipeline.
// Stall:
//   While the receiver holds out_ready low the result waits in the output
//   register and the stages behind it keep filling until they are full.
// ----------------------------------------------------------------------------
module turret_pi_control_with_wrap_unwind (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  tpwu_pkg::in_t                      in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output tpwu_pkg::out_t                     out_data,
    input  logic                               cfg_we,
    input  logic [tpwu_pkg::CfgIndexW-1:0]     cfg_index,
    input  logic [tpwu_pkg::CfgDataW-1:0]      cfg_data
);
    import tpwu_pkg::*;

    cfg_t cfg_reg;
    logic mid_valid;
    logic mid_ready;
    mid_t mid_data;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                RegEnable:        cfg_reg.enable         <= cfg_data[0];
                RegPropGain:      cfg_reg.prop_gain      <= $signed(cfg_data[15:0]);
                RegIntegGain:     cfg_reg.integ_gain     <= $signed(cfg_data[15:0]);
                RegIntegralLimit: cfg_reg.integral_limit <= cfg_data[22:0];
                RegTurnMargin:    cfg_reg.turn_margin    <= cfg_data[13:0];
                RegTurnBuffer:    cfg_reg.turn_buffer    <= cfg_data[13:0];
                default:          cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // Integral and products
    tpwu_integ_stage u_integ (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .mid_valid (mid_valid),
        .mid_ready (mid_ready),
        .mid_data  (mid_data)
    );

    // Sequencer and result register
    tpwu_ctrl_stage u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .mid_valid (mid_valid),
        .mid_ready (mid_ready),
        .mid_data  (mid_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

FILE: src/tpwu_integ_stage.sv
// ----------------------------------------------------------------------------
// tpwu_integ_stage
// Input register, clamped error integral and the two PI gain products.
// ----------------------------------------------------------------------------
module tpwu_integ_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  tpwu_pkg::cfg_t cfg,
    input  logic           in_valid,
    output logic           in_ready,
    input  tpwu_pkg::in_t  in_data,
    output logic           mid_valid,
    input  logic           mid_ready,
    output tpwu_pkg::mid_t mid_data
);
    import tpwu_pkg::*;

    logic               s1_valid_reg;
    in_t                s1_data_reg;
    logic               s2_valid_reg;
    mid_t               s2_data_reg;
    logic signed [23:0] integ_reg;
    logic signed [23:0] integ_next;

    logic               s1_ready;
    logic               s2_ready;
    logic               s1_move;
    logic signed [24:0] integ_sum;
    logic signed [24:0] lim_pos;
    logic signed [24:0] lim_neg;
    logic signed [24:0] integ_clamp;
    logic signed [31:0] prop_prod;
    logic signed [39:0] integ_prod;

    // Handshake: each stage takes a transaction when empty or draining
    always_comb
    begin
        s2_ready = !s2_valid_reg || mid_ready;
        s1_ready = !s1_valid_reg || s2_ready;
        s1_move  = s1_valid_reg && s2_ready;
    end

    assign in_ready  = s1_ready;
    assign mid_valid = s2_valid_reg;
    assign mid_data  = s2_data_reg;

    // Integral accumulate and clamp to +/- limit
    always_comb
    begin
        integ_sum   = $signed({integ_reg[23], integ_reg})
                    + $signed({{9{s1_data_reg.error_sample[15]}}, s1_data_reg.error_sample});
        lim_pos     = $signed({2'b00, cfg.integral_limit});
        lim_neg     = -lim_pos;
        integ_clamp = integ_sum;
        if (integ_sum > lim_pos)
        begin
            integ_clamp = lim_pos;
        end
        if (integ_sum < lim_neg)
        begin
            integ_clamp = lim_neg;
        end
        integ_next = integ_clamp[23:0];
    end

    // Gain products, Q20 fraction
    always_comb
    begin
        prop_prod  = 32'(s1_data_reg.error_sample) * 32'(cfg.prop_gain);
        integ_prod = 40'(integ_next) * 40'(cfg.integ_gain);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            integ_reg    <= '0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s1_move)
            begin
                integ_reg <= integ_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && s1_ready)
        begin
            s1_data_reg <= in_data;
        end
        if (s1_move)
        begin
            s2_data_reg.angle      <= s1_data_reg.angle_sample;
            s2_data_reg.prop_prod  <= prop_prod;
            s2_data_reg.integ_prod <= integ_prod;
        end
    end

endmodule

FILE: src/tpwu_ctrl_stage.sv
// ----------------------------------------------------------------------------
// tpwu_ctrl_stage
// Wrap tracking, unwind sequencing, PI scaling and the result register.
// ----------------------------------------------------------------------------
module tpwu_ctrl_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  tpwu_pkg::cfg_t cfg,
    input  logic           mid_valid,
    output logic           mid_ready,
    input  tpwu_pkg::mid_t mid_data,
    output logic           out_valid,
    input  logic           out_ready,
    output tpwu_pkg::out_t out_data
);
    import tpwu_pkg::*;

    logic               out_valid_reg;
    out_t               out_data_reg;
    logic signed [15:0] prev_angle_reg;
    logic signed [16:0] setpoint_reg;
    logic               wound_reg;
    logic               pending_reg;
    logic               clockwise_reg;
    logic               turning_reg;
    logic signed [15:0] held_reg;

    logic signed [16:0] setpoint_next;
    logic               wound_next;
    logic               pending_next;
    logic               clockwise_next;
    logic               turning_next;
    logic signed [15:0] effort_next;
    logic               unw_next;

    logic               move;
    logic signed [15:0] ang16;
    logic signed [15:0] mag16;
    logic signed [15:0] arm_thr;
    logic signed [16:0] ang17;
    logic signed [16:0] buf17;
    logic signed [17:0] ang18;
    logic signed [17:0] sp18;
    logic signed [17:0] buf18;
    logic               wrap_cross;
    logic               arm;
    logic               wound_flip;
    logic signed [40:0] pi_sum;
    logic signed [40:0] pi_bias;
    logic signed [20:0] pi_q;
    logic signed [15:0] pi_sat;

    assign mid_ready = !out_valid_reg || out_ready;
    assign move      = mid_valid && mid_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // PI sum, truncate toward zero, saturate
    always_comb
    begin
        pi_sum  = $signed({{9{mid_data.prop_prod[31]}}, mid_data.prop_prod})
                + $signed({mid_data.integ_prod[39], mid_data.integ_prod});
        pi_bias = pi_sum[40] ? pi_sum + 41'sd1048575 : pi_sum;
        pi_q    = pi_bias[40:PiFracBits];
        if (pi_q > EffortMax)
        begin
            pi_sat = 16'(EffortMax);
        end
        else if (pi_q < -EffortMax)
        begin
            pi_sat = -16'(EffortMax);
        end
        else
        begin
            pi_sat = pi_q[15:0];
        end
    end

    // Angle forms used by the compares
    always_comb
    begin
        ang16      = $signed({mid_data.angle[14], mid_data.angle});
        mag16      = (mid_data.angle < 0) ? -ang16 : ang16;
        arm_thr    = 16'(PiQ12) - $signed({2'b00, cfg.turn_margin});
        ang17      = $signed({{2{mid_data.angle[14]}}, mid_data.angle});
        buf17      = $signed({3'b000, cfg.turn_buffer});
        ang18      = $signed({{3{mid_data.angle[14]}}, mid_data.angle});
        buf18      = $signed({4'b0000, cfg.turn_buffer});
        wrap_cross = (ang16 > WrapQ12 && prev_angle_reg < -WrapQ12)
                  || (ang16 < -WrapQ12 && prev_angle_reg > WrapQ12);
    end

    // Wrap and unwind sequencing
    always_comb
    begin
        setpoint_next  = setpoint_reg;
        wound_next     = wound_reg;
        pending_next   = pending_reg;
        clockwise_next = clockwise_reg;
        turning_next   = turning_reg;
        effort_next    = held_reg;
        unw_next       = 1'b0;
        wound_flip     = wound_reg ^ wrap_cross;
        arm            = !turning_reg && wound_flip && (mag16 < arm_thr);
        sp18           = '0;

        if (cfg.enable)
        begin
            wound_next = wound_flip;
            if (arm)
            begin
                pending_next = 1'b1;
                if (mid_data.angle < 0)
                begin
                    setpoint_next = ang17 + buf17;
                end
                else if (mid_data.angle > 0)
                begin
                    setpoint_next = ang17 - buf17;
                end
            end
            sp18 = $signed({setpoint_next[16], setpoint_next});

            if (pending_next)
            begin
                // choosing a direction: previous effort repeats
                if (mid_data.angle > 0)
                begin
                    clockwise_next = 1'b1;
                    pending_next   = 1'b0;
                    turning_next   = 1'b1;
                end
                else if (mid_data.angle < 0)
                begin
                    clockwise_next = 1'b0;
                    pending_next   = 1'b0;
                    turning_next   = 1'b1;
                end
            end
            else if (clockwise_reg && turning_reg)
            begin
                effort_next = -16'(UnwindEffort);
                unw_next    = 1'b1;
                if (ang18 < sp18 && ang18 > sp18 - buf18)
                begin
                    turning_next = 1'b0;
                    wound_next   = 1'b0;
                end
            end
            else if (!clockwise_reg && turning_reg)
            begin
                effort_next = 16'(UnwindEffort);
                unw_next    = 1'b1;
                if (ang18 > sp18 && ang18 < sp18 + buf18)
                begin
                    turning_next = 1'b0;
                    wound_next   = 1'b0;
                end
            end
            else
            begin
                effort_next = pi_sat;
            end
        end
        else
        begin
            effort_next = '0;
        end
    end

    // Loop state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            prev_angle_reg <= '0;
            setpoint_reg   <= '0;
            wound_reg      <= 1'b0;
            pending_reg    <= 1'b0;
            clockwise_reg  <= 1'b0;
            turning_reg    <= 1'b0;
            held_reg       <= '0;
        end
        else
        begin
            if (mid_ready)
            begin
                out_valid_reg <= mid_valid;
            end
            if (move)
            begin
                prev_angle_reg <= ang16;
                setpoint_reg   <= setpoint_next;
                wound_reg      <= wound_next;
                pending_reg    <= pending_next;
                clockwise_reg  <= clockwise_next;
                turning_reg    <= turning_next;
                held_reg       <= effort_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_data_reg.drive_effort <= effort_next;
            out_data_reg.unwinding    <= unw_next;
            out_data_reg.wound_flag   <= wound_next;
        end
    end

endmodule

FILE: sim/turret_tick_checker.sv
// ----------------------------------------------------------------------------
// turret_tick_checker
// Watches the control tick and result channels of the turret PI block,
// predicts each result from its own copy of the loop state and registers,
// and compares the results field by field in arrival order.
// ----------------------------------------------------------------------------
module turret_tick_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  tpwu_pkg::in_t                  in_data,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  tpwu_pkg::out_t                 out_data,
    input  logic                           cfg_we,
    input  logic [tpwu_pkg::CfgIndexW-1:0] cfg_index,
    input  logic [tpwu_pkg::CfgDataW-1:0]  cfg_data,
    output int                             mismatches,
    output int                             awaiting
);
    timeunit 1ns;
    timeprecision 1ps;

    import tpwu_pkg::*;

    // Shadow registers and loop state
    cfg_t               regs          = '0;
    logic signed [15:0] last_angle    = '0;
    logic signed [23:0] integral      = '0;
    logic signed [16:0] setpoint      = '0;
    logic               wound         = 1'b0;
    logic               turn_pending  = 1'b0;
    logic               turn_cw       = 1'b0;
    logic               turning       = 1'b0;
    logic signed [15:0] last_effort   = '0;

    // Results still owed by the block, oldest first
    out_t               effort_q[$];

    initial mismatches = 0;
    initial awaiting   = 0;

    // One control tick: advance the shadow state, return the expected result
    function automatic out_t control_tick(in_t t);
        longint angle;
        longint err;
        longint lim;
        longint buf_w;
        longint prev;
        longint acc;
        longint mag;
        longint sp;
        longint effort;
        longint pi_sum;
        logic   unw;
        out_t   r;

        angle  = t.angle_sample;
        err    = t.error_sample;
        lim    = regs.integral_limit;
        buf_w  = regs.turn_buffer;
        prev   = last_angle;
        effort = last_effort;
        unw    = 1'b0;

        // integral runs whether or not the loop is enabled
        acc = longint'(integral) + err;
        if (acc > lim)
            acc = lim;
        if (acc < -lim)
            acc = -lim;
        integral = 24'(acc);

        if (regs.enable)
        begin
            mag = (angle < 0) ? -angle : angle;
            // wrap crossing in either direction toggles the wind flag
            if ((angle > WrapQ12 && prev < -WrapQ12) || (angle < -WrapQ12 && prev > WrapQ12))
                wound = !wound;

            // back inside pi minus margin: arm the unwind
            if (!turning && wound && mag < (PiQ12 - longint'(regs.turn_margin)))
            begin
                turn_pending = 1'b1;
                if (angle < 0)
                    setpoint = 17'(angle + buf_w);
                if (angle > 0)
                    setpoint = 17'(angle - buf_w);
            end

            sp = setpoint;
            if (turn_pending)
            begin
                // choosing a direction, effort held; zero angle keeps waiting
                if (angle > 0)
                begin
                    turn_cw      = 1'b1;
                    turn_pending = 1'b0;
                    turning      = 1'b1;
                end
                else if (angle < 0)
                begin
                    turn_cw      = 1'b0;
                    turn_pending = 1'b0;
                    turning      = 1'b1;
                end
            end
            else if (turn_cw && turning)
            begin
                effort = -UnwindEffort;
                unw    = 1'b1;
                if (angle < sp && angle > sp - buf_w)
                begin
                    turning = 1'b0;
                    wound   = 1'b0;
                end
            end
            else if (!turn_cw && turning)
            begin
                effort = UnwindEffort;
                unw    = 1'b1;
                if (angle > sp && angle < sp + buf_w)
                begin
                    turning = 1'b0;
                    wound   = 1'b0;
                end
            end
            else
            begin
                // PI output, truncated toward zero then saturated
                pi_sum = err * longint'($signed(regs.prop_gain))
                       + longint'(integral) * longint'($signed(regs.integ_gain));
                effort = pi_sum / (longint'(1) << PiFracBits);
                if (effort > EffortMax)
                    effort = EffortMax;
                if (effort < -EffortMax)
                    effort = -EffortMax;
            end
        end
        else
        begin
            effort = 0;
        end

        last_effort = 16'(effort);
        last_angle  = 16'(angle);

        r.drive_effort = 16'(effort);
        r.unwinding    = unw;
        r.wound_flag   = wound;
        return r;
    endfunction

    task automatic flag_field(string field, longint want, longint got);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        mismatches++;
    endtask

    // Channel monitor: results are retired before new ticks are queued
    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
        begin
            regs         = '0;
            last_angle   = '0;
            integral     = '0;
            setpoint     = '0;
            wound        = 1'b0;
            turn_pending = 1'b0;
            turn_cw      = 1'b0;
            turning      = 1'b0;
            last_effort  = '0;
            effort_q.delete();
            awaiting     = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    RegEnable:        regs.enable         = cfg_data[0];
                    RegPropGain:      regs.prop_gain      = cfg_data[15:0];
                    RegIntegGain:     regs.integ_gain     = cfg_data[15:0];
                    RegIntegralLimit: regs.integral_limit = cfg_data[22:0];
                    RegTurnMargin:    regs.turn_margin    = cfg_data[13:0];
                    RegTurnBuffer:    regs.turn_buffer    = cfg_data[13:0];
                    default: ;
                endcase
            end

            if (out_valid && out_ready)
            begin
                if (effort_q.size() == 0)
                begin
                    $display("%0t: result transaction with none expected, got %p",
                             $time, out_data);
                    mismatches++;
                end
                else
                begin
                    want = effort_q.pop_front();
                    if (out_data.drive_effort !== want.drive_effort)
                        flag_field("drive_effort", want.drive_effort, out_data.drive_effort);
                    if (out_data.unwinding !== want.unwinding)
                        flag_field("unwinding", want.unwinding, out_data.unwinding);
                    if (out_data.wound_flag !== want.wound_flag)
                        flag_field("wound_flag", want.wound_flag, out_data.wound_flag);
                end
            end

            if (in_valid && in_ready)
                effort_q.push_back(control_tick(in_data));

            awaiting = effort_q.size();
        end
    end

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the turret PI block: a directed run through wrap, arming,
// direction choice and unwind stop on both sides, then random wrap-and-unwind
// sequences mixed with noise under six register settings and three idling
// patterns, including one long receiver hold-off. The checker does the rest.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tpwu_pkg::*;

    localparam int CycleLimit   = 500000;
    localparam int TicksPerStep = 312;
    localparam int HoldCycles   = 400;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    in_t                  in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_t                 out_data;
    logic                 cfg_we    = 1'b0;
    logic [CfgIndexW-1:0] cfg_index = '0;
    logic [CfgDataW-1:0]  cfg_data  = '0;

    int mismatches;
    int awaiting;
    int send_idle_pct = 14;
    int recv_idle_pct = 83;
    bit hold_request  = 1'b0;
    int hold_left     = 0;
    int cycle_count   = 0;
    int ticks_sent    = 0;
    int cur_buffer    = 0;

    turret_pi_control_with_wrap_unwind dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    turret_tick_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    // Clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CycleLimit)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result receiver: random back-pressure, or a long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HoldCycles;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Offer one tick and wait for the transaction
    task automatic send_tick(int angle, int err);
        in_t t;
        t.angle_sample = 15'(angle);
        t.error_sample = 16'(err);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t;
        do
            @(posedge clk);
        while (!in_ready);
        ticks_sent++;
    endtask

    // Drop valid and wait for every owed result plus the pipeline depth
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (awaiting == 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(logic [CfgIndexW-1:0] idx, int value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CfgDataW'(value);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic apply_config(int en, int kp, int ki, int lim, int margin, int buf_w);
        write_reg(RegEnable, en);
        write_reg(RegPropGain, kp & 'hFFFF);
        write_reg(RegIntegGain, ki & 'hFFFF);
        write_reg(RegIntegralLimit, lim);
        write_reg(RegTurnMargin, margin);
        write_reg(RegTurnBuffer, buf_w);
        cur_buffer = buf_w;
    endtask

    // Errors: extremes, small values near zero, or anything
    function automatic int rand_error();
        case ($urandom_range(0, 7))
            0:       return -32768;
            1:       return 32767;
            2:       return int'($urandom_range(0, 200)) - 100;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    function automatic int clamp_angle(int a);
        if (a > 16383)
            return 16383;
        if (a < -16384)
            return -16384;
        return a;
    endfunction

    // Wrap crossing, return inside the arming band, then a march toward zero
    task automatic wrap_sequence();
        int side;
        int a;
        int steps;
        side = $urandom_range(0, 1) ? 1 : -1;
        send_tick(side * int'($urandom_range(12289, 16383)), rand_error());
        // now and then the crossing is missing
        if ($urandom_range(0, 4) != 0)
            side = -side;
        send_tick(side * int'($urandom_range(12289, 16383)), rand_error());
        // a zero angle leaves the direction undecided
        if ($urandom_range(0, 7) == 0)
            send_tick(0, rand_error());
        a = side * int'($urandom_range(6000, 12867));
        send_tick(a, rand_error());
        steps = $urandom_range(1, 12);
        repeat (steps)
        begin
            a = clamp_angle(a - side * int'($urandom_range(0, cur_buffer > 0 ? cur_buffer : 500)));
            send_tick(a, rand_error());
        end
    endtask

    // Main sequence
    initial
    begin
        int target;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // registers at reset: loop disabled
        send_tick(0, 0);
        send_tick(16383, 32767);
        drain();

        apply_config(1, 256, 16, 8388607, 0, 2000);
        send_tick(0, 0);
        send_tick(16383, 32767);
        send_tick(-16384, -32768);  // wrap, still beyond pi
        send_tick(-12000, 0);       // arms, counter-clockwise chosen
        send_tick(-11000, 100);
        send_tick(-9000, -100);     // lands in window, unwind stops
        send_tick(13000, 5);
        send_tick(-13000, 5);       // wrap, no arming yet
        send_tick(0, 0);            // zero angle: stays pending
        send_tick(0, 0);
        send_tick(5000, 0);         // clockwise chosen
        send_tick(4000, 0);
        send_tick(2000, 0);         // stop on the clockwise side
        send_tick(-13000, 32767);
        send_tick(13000, 32767);    // wrap the other way
        send_tick(12000, 32767);
        send_tick(11000, -32768);
        send_tick(9000, -32768);
        drain();

        // Random phases: idling pattern changes every two register settings
        for (int p = 0; p < 6; p++)
        begin
            case (p / 2)
                0:
                begin
                    send_idle_pct = 14;
                    recv_idle_pct = 83;
                end
                1:
                begin
                    send_idle_pct = 83;
                    recv_idle_pct = 14;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            case (p)
                0: apply_config(1, 256, 16, 8388607, 0, 2000);
                1: apply_config(1, -32768, 32767, 0, 12868, 12868);
                2: apply_config(0, 32767, -32768, 100000, 500, 0);
                3: apply_config(1, 32767, -32768, 8388607, 300, 1500);
                4: apply_config(1, int'($urandom_range(0, 65535)) - 32768,
                                int'($urandom_range(0, 65535)) - 32768,
                                $urandom_range(0, 8388607),
                                $urandom_range(0, 1500), $urandom_range(200, 4000));
                default: apply_config(1, -256, 512, 40000, 800, 700);
            endcase

            // long receiver hold-off while ticks keep coming
            if (p == 4)
                hold_request = 1'b1;

            target = ticks_sent + TicksPerStep;
            while (ticks_sent < target)
            begin
                if ($urandom_range(0, 9) < 7)
                    wrap_sequence();
                else
                    send_tick(int'($urandom_range(0, 32767)) - 16384, rand_error());
            end
            drain();
        end

        repeat (4) @(posedge clk);
        if (mismatches == 0 && awaiting == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: files.f
src/tpwu_pkg.sv
src/tpwu_integ_stage.sv
src/tpwu_ctrl_stage.sv
src/turret_pi_control_with_wrap_unwind.sv
sim/turret_tick_checker.sv
sim/tb.sv
